// ===== rtl/dtwp_pkg.sv =====
// Shared types and constants for the DDS tuning word programmer.
// No dependencies; used by every module of the block.
package dtwp_pkg;

  // Field widths
  localparam int FREQ_W     = 30;
  localparam int REF_W      = 28;
  localparam int OFFSET_W   = 27;
  localparam int TWA_W      = 5;
  localparam int WORD_W     = 32;
  localparam int HDR_W      = 8;
  localparam int SUM_W      = 31;           // freq + offset never exceeds 31 bits
  localparam int DIVISOR_W  = REF_W + 2;    // reference times four
  localparam int DIV_STEPS  = SUM_W + WORD_W; // dividend is sum followed by 32 zeros
  localparam int STEP_W     = $clog2(DIV_STEPS);

  // APB register map
  localparam int PADDR_W    = 3;
  localparam int PDATA_W    = 32;
  localparam logic REG_OFFSET_HZ = 1'b0;    // paddr[2] decode
  localparam logic REG_TWA       = 1'b1;

  // Reset values
  localparam logic [OFFSET_W-1:0] OFFSET_RESET = OFFSET_W'(9000000);
  localparam logic [TWA_W-1:0]    TWA_RESET    = TWA_W'(4);

  localparam int WORD_BYTES_DEFAULT = 4;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIVIDE,
    ST_SEND
  } dtwp_state_t;

  typedef struct packed {
    logic active;    // frame being shifted out
    logic finished;  // final bit transaction just completed
  } dtwp_ser_status_t;

endpackage

// ===== rtl/dtwp_divider.sv =====
// Iterative restoring divider: {sum, 32'b0} / divisor, one quotient bit per cycle.
// Depends on dtwp_pkg. Keeps only the low 32 quotient bits.
module dtwp_divider (
  input  logic                            clk,
  input  logic                            rst,
  input  logic                            start,
  input  logic [dtwp_pkg::SUM_W-1:0]      dividend,
  input  logic [dtwp_pkg::DIVISOR_W-1:0]  divisor,
  output logic                            done,
  output logic [dtwp_pkg::WORD_W-1:0]     quotient
);

  logic                             running;
  logic [dtwp_pkg::STEP_W-1:0]      step;
  logic [dtwp_pkg::SUM_W-1:0]       num;
  logic [dtwp_pkg::DIVISOR_W-1:0]   rem;
  logic [dtwp_pkg::DIVISOR_W-1:0]   dvs;
  logic [dtwp_pkg::DIVISOR_W:0]     trial;
  logic [dtwp_pkg::DIVISOR_W:0]     diff;
  logic                             ge;
  logic [dtwp_pkg::DIVISOR_W-1:0]   rem_next;

  // shared compare/subtract unit
  always_comb begin
    trial    = {rem, num[dtwp_pkg::SUM_W-1]};
    ge       = (trial >= {1'b0, dvs});
    diff     = trial - {1'b0, dvs};
    rem_next = ge ? diff[dtwp_pkg::DIVISOR_W-1:0] : trial[dtwp_pkg::DIVISOR_W-1:0];
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      running <= 1'b0;
      done    <= 1'b0;
      step    <= '0;
    end else begin
      done <= 1'b0;
      if (start) begin
        running <= 1'b1;
        step    <= '0;
      end else if (running) begin
        step <= step + 1'b1;
        if (step == dtwp_pkg::STEP_W'(dtwp_pkg::DIV_STEPS - 1)) begin
          running <= 1'b0;
          done    <= 1'b1;
        end
      end
    end
  end

  // datapath, no reset needed
  always_ff @(posedge clk) begin
    if (start) begin
      num      <= dividend;
      dvs      <= divisor;
      rem      <= '0;
      quotient <= '0;
    end else if (running) begin
      num      <= {num[dtwp_pkg::SUM_W-2:0], 1'b0};
      rem      <= rem_next;
      quotient <= {quotient[dtwp_pkg::WORD_W-2:0], ge};
    end
  end

endmodule

// ===== rtl/dtwp_serializer.sv =====
// Serial frame shifter: address header then low WORD_BYTES bytes of the word, msb first.
// Depends on dtwp_pkg. Presents one bit per transaction on a valid/stall channel.
module dtwp_serializer #(
  parameter int WORD_BYTES = dtwp_pkg::WORD_BYTES_DEFAULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             load,
  input  logic [dtwp_pkg::TWA_W-1:0]       addr,
  input  logic [8*WORD_BYTES-1:0]          word,
  input  logic                             out_stall,
  output logic                             out_valid,
  output logic                             serial_bit,
  output logic                             last_bit,
  output dtwp_pkg::dtwp_ser_status_t       status
);

  localparam int FRAME_W = dtwp_pkg::HDR_W + 8*WORD_BYTES;
  localparam int CNT_W   = $clog2(FRAME_W + 1);

  logic [FRAME_W-1:0] shreg;
  logic [CNT_W-1:0]   remaining;
  logic               active;
  logic               finished;
  logic               xfer;

  assign xfer       = active && !out_stall;
  assign out_valid  = active;
  assign serial_bit = shreg[FRAME_W-1];
  assign last_bit   = (remaining == CNT_W'(1));
  assign status     = '{active: active, finished: finished};

  always_ff @(posedge clk) begin
    if (rst) begin
      active    <= 1'b0;
      finished  <= 1'b0;
      remaining <= '0;
    end else begin
      finished <= 1'b0;
      if (load) begin
        active    <= 1'b1;
        remaining <= CNT_W'(FRAME_W);
      end else if (xfer) begin
        remaining <= remaining - 1'b1;
        if (last_bit) begin
          active   <= 1'b0;
          finished <= 1'b1;
        end
      end
    end
  end

  always_ff @(posedge clk) begin
    if (load) begin
      shreg <= {(dtwp_pkg::HDR_W)'(addr), word};
    end else if (xfer) begin
      shreg <= {shreg[FRAME_W-2:0], 1'b0};
    end
  end

endmodule

// ===== rtl/dds_tuning_word_programmer_unit.sv =====
// DDS tuning word programmer, top level. Depends on dtwp_pkg, dtwp_divider, dtwp_serializer.
// Sequence: a changed request is divided in the divider (one quotient bit per cycle), then the
// frame is loaded and sent as 8 + 8*WORD_BYTES bit transactions (40 by default), subject to output
// stall. No new request is taken until the frame has gone; an unchanged request is accepted
// without a frame. in_stall high from divide start to after last bit.
// Reset (synchronous, rst high): idle, last pair cleared to zero, registers to defaults.
module dds_tuning_word_programmer_unit #(
  parameter int WORD_BYTES = dtwp_pkg::WORD_BYTES_DEFAULT
) (
  input  logic                          clk,
  input  logic                          rst,
  // request channel
  input  logic                          in_valid,
  output logic                          in_stall,
  input  logic [dtwp_pkg::FREQ_W-1:0]   request_freq,
  input  logic [dtwp_pkg::REF_W-1:0]    reference_clock,
  // serial bit channel
  output logic                          out_valid,
  input  logic                          out_stall,
  output logic                          serial_bit,
  output logic                          last_bit,
  // APB configuration port
  input  logic                          psel,
  input  logic                          penable,
  input  logic                          pwrite,
  input  logic [dtwp_pkg::PADDR_W-1:0]  paddr,
  input  logic [dtwp_pkg::PDATA_W-1:0]  pwdata,
  output logic [dtwp_pkg::PDATA_W-1:0]  prdata,
  output logic                          pready
);

  // Configuration registers
  logic [dtwp_pkg::OFFSET_W-1:0] offset_hz;
  logic [dtwp_pkg::TWA_W-1:0]    tuning_word_address;
  logic                          cfg_write;

  assign pready    = 1'b1;
  assign cfg_write = psel && penable && pwrite && pready;

  always_ff @(posedge clk) begin
    if (rst) begin
      offset_hz           <= dtwp_pkg::OFFSET_RESET;
      tuning_word_address <= dtwp_pkg::TWA_RESET;
    end else if (cfg_write) begin
      case (paddr[2])
        dtwp_pkg::REG_OFFSET_HZ: offset_hz           <= pwdata[dtwp_pkg::OFFSET_W-1:0];
        dtwp_pkg::REG_TWA:       tuning_word_address <= pwdata[dtwp_pkg::TWA_W-1:0];
        default: ;
      endcase
    end
  end

  always_comb begin
    case (paddr[2])
      dtwp_pkg::REG_OFFSET_HZ: prdata = dtwp_pkg::PDATA_W'(offset_hz);
      dtwp_pkg::REG_TWA:       prdata = dtwp_pkg::PDATA_W'(tuning_word_address);
      default:                 prdata = '0;
    endcase
  end

  // Last pair acted on; (0, 0) after reset counts as already sent
  logic [dtwp_pkg::FREQ_W-1:0] last_freq;
  logic [dtwp_pkg::REF_W-1:0]  last_ref;
  logic                        in_accept;
  logic                        changed;

  assign in_accept = in_valid && !in_stall;
  assign changed   = (request_freq != last_freq) || (reference_clock != last_ref);

  always_ff @(posedge clk) begin
    if (rst) begin
      last_freq <= '0;
      last_ref  <= '0;
    end else if (in_accept && changed) begin
      last_freq <= request_freq;
      last_ref  <= reference_clock;
    end
  end

  // Divider operands: sum is at most 31 bits, divisor is ref * 4.
  // A zero divisor drives every quotient bit to one, giving all-ones.
  logic [dtwp_pkg::SUM_W-1:0]     sum;
  logic [dtwp_pkg::DIVISOR_W-1:0] divisor;
  logic                           div_start;
  logic                           div_done;
  logic [dtwp_pkg::WORD_W-1:0]    quotient;

  assign sum     = dtwp_pkg::SUM_W'(request_freq) + dtwp_pkg::SUM_W'(offset_hz);
  assign divisor = {reference_clock, 2'b00};

  dtwp_divider u_div (
    .clk      (clk),
    .rst      (rst),
    .start    (div_start),
    .dividend (sum),
    .divisor  (divisor),
    .done     (div_done),
    .quotient (quotient)
  );

  // Serial frame
  logic                         ser_load;
  dtwp_pkg::dtwp_ser_status_t   ser_status;

  dtwp_serializer #(
    .WORD_BYTES (WORD_BYTES)
  ) u_ser (
    .clk        (clk),
    .rst        (rst),
    .load       (ser_load),
    .addr       (tuning_word_address),
    .word       (quotient[8*WORD_BYTES-1:0]),
    .out_stall  (out_stall),
    .out_valid  (out_valid),
    .serial_bit (serial_bit),
    .last_bit   (last_bit),
    .status     (ser_status)
  );

  // Sequencer
  dtwp_pkg::dtwp_state_t state, state_next;

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= dtwp_pkg::ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

  always_comb begin
    state_next = state;
    in_stall   = 1'b1;
    div_start  = 1'b0;
    ser_load   = 1'b0;
    case (state)
      dtwp_pkg::ST_IDLE: begin
        in_stall = 1'b0;
        if (in_accept && changed) begin
          div_start  = 1'b1;
          state_next = dtwp_pkg::ST_DIVIDE;
        end
      end
      dtwp_pkg::ST_DIVIDE: begin
        if (div_done) begin
          ser_load   = 1'b1;
          state_next = dtwp_pkg::ST_SEND;
        end
      end
      dtwp_pkg::ST_SEND: begin
        // finished pulses the cycle after the final bit transaction
        if (ser_status.finished) begin
          state_next = dtwp_pkg::ST_IDLE;
        end
      end
      default: state_next = dtwp_pkg::ST_IDLE;
    endcase
  end

endmodule

// ===== rtl/dtwp_checker.sv =====
// Port-level checker for the DDS tuning word programmer, bound to the top level.
// Depends on dds_tuning_word_programmer_unit port names only.
module dtwp_checker (
  input logic clk,
  input logic rst,
  input logic in_stall,
  input logic out_valid,
  input logic out_stall,
  input logic serial_bit,
  input logic last_bit
);

  // stalled bit holds
  a_out_hold: assert property (@(posedge clk) disable iff (rst)
    out_valid && out_stall |=> out_valid && $stable(serial_bit) && $stable(last_bit))
    else $error("stalled serial bit changed");

  // no request taken while a frame is on the line
  a_busy_stall: assert property (@(posedge clk) disable iff (rst)
    out_valid |-> in_stall)
    else $error("input accepted during frame");

  // frame ends after the flagged bit
  a_frame_end: assert property (@(posedge clk) disable iff (rst)
    out_valid && !out_stall && last_bit |=> !out_valid)
    else $error("bits after final bit");

  // nothing on the line out of reset
  a_reset_quiet: assert property (@(posedge clk)
    rst |=> !out_valid)
    else $error("output valid after reset");

endmodule

bind dds_tuning_word_programmer_unit dtwp_checker u_dtwp_checker (
  .clk        (clk),
  .rst        (rst),
  .in_stall   (in_stall),
  .out_valid  (out_valid),
  .out_stall  (out_stall),
  .serial_bit (serial_bit),
  .last_bit   (last_bit)
);

// ===== sim/tb_dds_tuning_word_programmer_unit.sv =====
// Testbench for dds_tuning_word_programmer_unit: checks each serial frame against a predicted frame.
// Depends on dtwp_pkg and the RTL of the block; needs no other file.
module tb_dds_tuning_word_programmer_unit;

  localparam int WORD_BYTES     = dtwp_pkg::WORD_BYTES_DEFAULT;
  localparam int WATCHDOG_LIMIT = 2000;  // must exceed the longest quiet stretch: receiver hold + divide
  localparam int HOLD_CYCLES    = 400;   // long receiver hold-off that backs up the input
  localparam int SETTLE_CYCLES  = 110;   // about one full divide + frame
  localparam int RANDOM_PHASES  = 5;
  localparam int CHANGES_PER_PHASE = 13;

  // Register addresses, decoded on paddr[2]
  localparam logic [dtwp_pkg::PADDR_W-1:0] ADDR_OFFSET = {dtwp_pkg::REG_OFFSET_HZ, 2'b00};
  localparam logic [dtwp_pkg::PADDR_W-1:0] ADDR_TWA    = {dtwp_pkg::REG_TWA, 2'b00};

  localparam logic [dtwp_pkg::FREQ_W-1:0] FREQ_MAX = '1;
  localparam logic [dtwp_pkg::REF_W-1:0]  REF_MAX  = '1;

  // One bit on the serial line as the receiver should see it
  typedef struct packed {
    logic data;
    logic strobe;
  } line_bit_t;

  // Tracks the kept request pair and configuration, and queues the serial bits
  // that each accepted request should produce.
  class tuning_frame_tracker;
    logic [dtwp_pkg::OFFSET_W-1:0] offset_hz;
    logic [dtwp_pkg::TWA_W-1:0]    word_addr;
    logic [dtwp_pkg::FREQ_W-1:0]   kept_freq;
    logic [dtwp_pkg::REF_W-1:0]    kept_ref;
    line_bit_t                     pending_bits[$];
    int                            mismatches;

    function new();
      offset_hz  = dtwp_pkg::OFFSET_RESET;
      word_addr  = dtwp_pkg::TWA_RESET;
      kept_freq  = '0;
      kept_ref   = '0;
      mismatches = 0;
    endfunction

    function void apply_register(logic [dtwp_pkg::PADDR_W-1:0] addr,
                                 logic [dtwp_pkg::PDATA_W-1:0] data);
      case (addr)
        ADDR_OFFSET: offset_hz = data[dtwp_pkg::OFFSET_W-1:0];
        ADDR_TWA:    word_addr = data[dtwp_pkg::TWA_W-1:0];
        default: ;
      endcase
    endfunction

    // floor((freq + offset) * 2^32 / (4 * refclk)), low 32 bits; all ones for a zero divisor
    function logic [dtwp_pkg::WORD_W-1:0] tuning_word(logic [dtwp_pkg::FREQ_W-1:0] freq,
                                                      logic [dtwp_pkg::REF_W-1:0]  refclk);
      logic [dtwp_pkg::WORD_W-1:0] sum;
      logic [63:0]                 dividend;
      logic [63:0]                 divisor;
      if (refclk == '0)
        return '1;
      sum      = dtwp_pkg::WORD_W'(freq) + dtwp_pkg::WORD_W'(offset_hz);
      dividend = {sum, 32'h0};
      divisor  = 64'(refclk) << 2;
      return dtwp_pkg::WORD_W'(dividend / divisor);
    endfunction

    function void note_request(logic [dtwp_pkg::FREQ_W-1:0] freq,
                               logic [dtwp_pkg::REF_W-1:0]  refclk);
      logic [dtwp_pkg::WORD_W-1:0] word;
      logic [dtwp_pkg::HDR_W-1:0]  header;
      if (freq == kept_freq && refclk == kept_ref)
        return;
      word      = tuning_word(freq, refclk);
      kept_freq = freq;
      kept_ref  = refclk;
      header    = dtwp_pkg::HDR_W'(word_addr);
      for (int i = dtwp_pkg::HDR_W - 1; i >= 0; i--)
        pending_bits.push_back('{data: header[i], strobe: 1'b0});
      for (int i = 8 * WORD_BYTES - 1; i >= 0; i--)
        pending_bits.push_back('{data: word[i], strobe: (i == 0)});
    endfunction

    function void check_bit(logic data, logic strobe);
      line_bit_t want;
      if (pending_bits.size() == 0) begin
        $error("serial transaction with no frame pending: serial_bit=%0b last_bit=%0b",
               data, strobe);
        mismatches++;
        return;
      end
      want = pending_bits.pop_front();
      if (data !== want.data) begin
        $error("serial_bit mismatch: expected %0b, actual %0b", want.data, data);
        mismatches++;
      end
      if (strobe !== want.strobe) begin
        $error("last_bit mismatch: expected %0b, actual %0b", want.strobe, strobe);
        mismatches++;
      end
    endfunction

    function int pending();
      return pending_bits.size();
    endfunction
  endclass

  // DUT connections; every input starts at a known value
  logic                          clk = 1'b0;
  logic                          rst = 1'b1;
  logic                          in_valid = 1'b0;
  logic                          in_stall;
  logic [dtwp_pkg::FREQ_W-1:0]   request_freq = '0;
  logic [dtwp_pkg::REF_W-1:0]    reference_clock = '0;
  logic                          out_valid;
  logic                          out_stall = 1'b0;
  logic                          serial_bit;
  logic                          last_bit;
  logic                          psel = 1'b0;
  logic                          penable = 1'b0;
  logic                          pwrite = 1'b0;
  logic [dtwp_pkg::PADDR_W-1:0]  paddr = '0;
  logic [dtwp_pkg::PDATA_W-1:0]  pwdata = '0;
  logic [dtwp_pkg::PDATA_W-1:0]  prdata;
  logic                          pready;

  tuning_frame_tracker board = new();

  // Shared knobs between the request driver and the serial receiver
  bit hold_req = 1'b0;  // receiver does one long hold-off, then clears this
  bit no_idle  = 1'b0;  // both sides run back to back

  // Last pair offered, so the random part can repeat it on purpose
  logic [dtwp_pkg::FREQ_W-1:0] last_sent_freq = '0;
  logic [dtwp_pkg::REF_W-1:0]  last_sent_ref  = '0;

  dds_tuning_word_programmer_unit #(
    .WORD_BYTES(WORD_BYTES)
  ) u_dut (
    .clk            (clk),
    .rst            (rst),
    .in_valid       (in_valid),
    .in_stall       (in_stall),
    .request_freq   (request_freq),
    .reference_clock(reference_clock),
    .out_valid      (out_valid),
    .out_stall      (out_stall),
    .serial_bit     (serial_bit),
    .last_bit       (last_bit),
    .psel           (psel),
    .penable        (penable),
    .pwrite         (pwrite),
    .paddr          (paddr),
    .pwdata         (pwdata),
    .prdata         (prdata),
    .pready         (pready)
  );

  initial begin
    forever #10 clk = ~clk;
  end

  // Sender-side gap: mostly none, some short, a few long
  function automatic int pick_gap();
    int pick;
    if (no_idle)
      return 0;
    pick = $urandom_range(0, 9);
    if (pick < 5)
      return 0;
    else if (pick < 9)
      return $urandom_range(1, 3);
    else
      return $urandom_range(10, 40);
  endfunction

  // Offer one request and hold it until accepted. valid stays high across
  // back-to-back transactions; it only drops when a gap is taken or a phase finishes.
  task automatic send_request(input logic [dtwp_pkg::FREQ_W-1:0] freq,
                              input logic [dtwp_pkg::REF_W-1:0]  refclk);
    int gap;
    gap = pick_gap();
    if (gap > 0) begin
      in_valid <= 1'b0;
      repeat (gap) @(posedge clk);
    end
    in_valid        <= 1'b1;
    request_freq    <= freq;
    reference_clock <= refclk;
    do @(posedge clk); while (in_stall);
    board.note_request(freq, refclk);
    last_sent_freq = freq;
    last_sent_ref  = refclk;
  endtask

  // Drop valid, wait for every predicted bit, then let the block settle
  task automatic finish_phase();
    in_valid <= 1'b0;
    while (board.pending() != 0) @(posedge clk);
    repeat (SETTLE_CYCLES) @(posedge clk);
  endtask

  // APB write: setup cycle, then access cycle until pready
  task automatic write_register(input logic [dtwp_pkg::PADDR_W-1:0] addr,
                                input logic [dtwp_pkg::PDATA_W-1:0] data);
    psel    <= 1'b1;
    penable <= 1'b0;
    pwrite  <= 1'b1;
    paddr   <= addr;
    pwdata  <= data;
    @(posedge clk);
    penable <= 1'b1;
    do @(posedge clk); while (!pready);
    psel    <= 1'b0;
    penable <= 1'b0;
    @(posedge clk);
    board.apply_register(addr, data);
  endtask

  function automatic logic [dtwp_pkg::FREQ_W-1:0] random_freq();
    case ($urandom_range(0, 3))
      0:       return dtwp_pkg::FREQ_W'($urandom);
      1:       return dtwp_pkg::FREQ_W'($urandom_range(0, 1000000000));
      2:       return dtwp_pkg::FREQ_W'($urandom_range(0, 1000));
      default: return FREQ_MAX;
    endcase
  endfunction

  // Small references give quotients wider than 32 bits; zero now and then
  function automatic logic [dtwp_pkg::REF_W-1:0] random_ref();
    case ($urandom_range(0, 4))
      0:       return dtwp_pkg::REF_W'($urandom);
      1:       return dtwp_pkg::REF_W'($urandom_range(1, 250000000));
      2:       return dtwp_pkg::REF_W'($urandom_range(1, 64));
      3:       return dtwp_pkg::REF_W'($urandom_range(100000000, 250000000));
      default: return ($urandom_range(0, 9) == 0) ? '0 :
                      dtwp_pkg::REF_W'($urandom_range(1, 4000000));
    endcase
  endfunction

  // Mostly fresh pairs; about one in five repeats the last pair (no frame).
  // Fresh pairs sometimes change only one of the two fields.
  task automatic run_random_phase(input int changes);
    int done_changes;
    done_changes = 0;
    while (done_changes < changes) begin
      case ($urandom_range(0, 9))
        0, 1: send_request(last_sent_freq, last_sent_ref);
        2: begin
          send_request(random_freq(), last_sent_ref);
          done_changes++;
        end
        3: begin
          send_request(last_sent_freq, random_ref());
          done_changes++;
        end
        default: begin
          send_request(random_freq(), random_ref());
          done_changes++;
        end
      endcase
    end
  endtask

  // Serial receiver: random stall runs, the odd long stall, quiet stretches,
  // and one long hold-off when asked for.
  initial begin
    int pick;
    int run;
    forever begin
      if (hold_req) begin
        out_stall <= 1'b1;
        repeat (HOLD_CYCLES) @(posedge clk);
        hold_req = 1'b0;
      end else if (no_idle) begin
        out_stall <= 1'b0;
        @(posedge clk);
      end else begin
        pick = $urandom_range(0, 9);
        if (pick < 6) begin
          out_stall <= 1'b0;
          run = $urandom_range(1, 8);
        end else if (pick < 9) begin
          out_stall <= 1'b1;
          run = $urandom_range(1, 3);
        end else begin
          out_stall <= 1'b1;
          run = $urandom_range(10, 60);
        end
        repeat (run) @(posedge clk);
      end
    end
  end

  // Every accepted serial transaction is checked against the oldest predicted bit
  always @(posedge clk) begin
    if (!rst && out_valid && !out_stall)
      board.check_bit(serial_bit, last_bit);
  end

  // Watchdog: consecutive cycles with no transaction anywhere
  int idle_cycles = 0;
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall) || (psel && penable)) begin
      idle_cycles <= 0;
    end else begin
      idle_cycles <= idle_cycles + 1;
      if (idle_cycles >= WATCHDOG_LIMIT) begin
        $error("no transaction for %0d cycles", WATCHDOG_LIMIT);
        $display("== FAIL ==");
        $finish;
      end
    end
  end

  initial begin
    repeat (4) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // Reset configuration. The zero pair matches the cleared state: no frame.
    send_request('0, '0);
    send_request('0, '0);
    send_request(dtwp_pkg::FREQ_W'(1000000), dtwp_pkg::REF_W'(10000000));
    send_request(dtwp_pkg::FREQ_W'(1000000), dtwp_pkg::REF_W'(10000000));  // unchanged
    send_request(FREQ_MAX, dtwp_pkg::REF_W'(1));        // quotient far beyond 32 bits
    send_request(FREQ_MAX, REF_MAX);
    send_request('0, REF_MAX);
    send_request(dtwp_pkg::FREQ_W'(12345), '0);         // zero reference -> all ones
    send_request(dtwp_pkg::FREQ_W'(12345), '0);         // unchanged, still no frame
    send_request('0, '0);                               // zero pair, now a change
    finish_phase();

    // No offset, top header address. A new offset alone must not cause a frame.
    write_register(ADDR_OFFSET, '0);
    write_register(ADDR_TWA, dtwp_pkg::PDATA_W'(31));
    send_request('0, '0);
    send_request('0, dtwp_pkg::REF_W'(1));              // sum of zero -> word zero
    send_request(dtwp_pkg::FREQ_W'(1000000000), dtwp_pkg::REF_W'(250000000));
    // freq alone changes, then ref alone changes
    send_request(dtwp_pkg::FREQ_W'(1000000001), dtwp_pkg::REF_W'(250000000));
    send_request(dtwp_pkg::FREQ_W'(1000000001), dtwp_pkg::REF_W'(249999999));
    finish_phase();

    // Offset and address at full width (upper pwdata bits set), header address zero
    write_register(ADDR_OFFSET, '1);
    write_register(ADDR_TWA, dtwp_pkg::PDATA_W'(32'hFFFF_FFE0));
    send_request(FREQ_MAX, dtwp_pkg::REF_W'(1));
    send_request(FREQ_MAX, dtwp_pkg::REF_W'(3));
    send_request('0, REF_MAX);
    send_request(dtwp_pkg::FREQ_W'(1), dtwp_pkg::REF_W'(1));
    send_request(dtwp_pkg::FREQ_W'(2), dtwp_pkg::REF_W'(1));
    finish_phase();

    // Random part, a new configuration per phase. The first phase carries the
    // long receiver hold-off while requests keep coming; the second runs with
    // no idling on either side and raw 32-bit register writes.
    for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
      if (phase == 1) begin
        write_register(ADDR_OFFSET, dtwp_pkg::PDATA_W'($urandom));
        write_register(ADDR_TWA, dtwp_pkg::PDATA_W'($urandom));
      end else begin
        write_register(ADDR_OFFSET, dtwp_pkg::PDATA_W'($urandom_range(0, 100000000)));
        write_register(ADDR_TWA, dtwp_pkg::PDATA_W'($urandom_range(0, 31)));
      end
      hold_req = (phase == 0);
      no_idle  = (phase == 1);
      run_random_phase(CHANGES_PER_PHASE);
      finish_phase();
      no_idle = 1'b0;
    end

    if (board.pending() != 0)
      $error("%0d predicted serial bits never arrived", board.pending());
    if (board.mismatches == 0 && board.pending() == 0)
      $display("== PASS ==");
    else
      $display("== FAIL ==");
    $finish;
  end

endmodule
